// ===== rtl/u2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types, constants and the code point to CP1252 mapping function.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACCUM_W = 21;
  localparam int unsigned SYM_CNT = 27;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ACCUM_W-1:0] accum_t;
  typedef logic [1:0]         count_t;

  // Lead byte patterns (casez, ? is don't care)
  localparam byte_t LEAD_ASCII = 8'b0???????;
  localparam byte_t LEAD_TWO   = 8'b110?????;
  localparam byte_t LEAD_THREE = 8'b1110????;
  localparam byte_t LEAD_FOUR  = 8'b11110???;

  localparam byte_t QMARK_BYTE = 8'h3F;

  typedef logic [15:0] sym_cp_t;

  localparam sym_cp_t SYM_CP [SYM_CNT] = '{
    16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
    16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
  };

  localparam byte_t SYM_BYTE [SYM_CNT] = '{
    8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91,
    8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
    8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
  };

  // C1 codes with no assigned glyph pass through unchanged
  localparam byte_t C1_PASS [5] = '{8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D};

  function automatic byte_t map_cp(input accum_t cp);
    byte_t res;
    logic  hit;
    res = QMARK_BYTE;
    hit = 1'b0;
    for (int i = 0; i < SYM_CNT; i++) begin
      if (!hit && cp == accum_t'(SYM_CP[i])) begin
        res = SYM_BYTE[i];
        hit = 1'b1;
      end
    end
    for (int i = 0; i < 5; i++) begin
      if (!hit && cp == accum_t'(C1_PASS[i])) begin
        res = cp[BYTE_W-1:0];
        hit = 1'b1;
      end
    end
    if (!hit && (cp <= accum_t'(8'h7F) ||
                 (cp >= accum_t'(8'hA0) && cp <= accum_t'(8'hFF)))) begin
      res = cp[BYTE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/utf8_to_cp1252_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_cp1252_decoder_unit
// UTF-8 byte stream in, Windows-1252 bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_byte takes one UTF-8 byte per transfer.
//   Output channel out_valid/out_ready/out_byte gives one CP1252 byte for each
//   completed code point; unmappable code points give 0x3F. Stray continuation
//   bytes and invalid lead bytes give nothing, as does a code point of zero.
//   A completing byte's result is registered into out_byte at its transfer,
//   showing in the next cycle. Throughput: one byte per cycle unless stalled;
//   the decode and table match sit before the single output register.
//   in_ready is high while the output register is empty or being drained, so
//   a stalled receiver holds at most one result and backs up the input only
//   while that result waits.
//   Reset (rst, synchronous) empties the output register and returns the
//   decoder to expecting a lead byte with a cleared accumulator.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_decoder_unit
  import u2c_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte
);

  count_t bytes_left, bytes_left_next;
  accum_t code_accum, code_accum_next;
  logic   emit;
  logic   in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    bytes_left_next = bytes_left;
    code_accum_next = code_accum;
    emit            = 1'b0;
    if (bytes_left != 2'd0) begin
      code_accum_next = {code_accum[ACCUM_W-7:0], in_byte[5:0]};
      bytes_left_next = bytes_left - 2'd1;
      emit            = (bytes_left_next == 2'd0) && (code_accum_next != '0);
    end else begin
      unique casez (in_byte)
        LEAD_ASCII: begin
          code_accum_next = accum_t'(in_byte[6:0]);
          emit            = (in_byte[6:0] != 7'd0);
        end
        LEAD_TWO: begin
          code_accum_next = accum_t'(in_byte[4:0]);
          bytes_left_next = 2'd1;
        end
        LEAD_THREE: begin
          code_accum_next = accum_t'(in_byte[3:0]);
          bytes_left_next = 2'd2;
        end
        LEAD_FOUR: begin
          code_accum_next = accum_t'(in_byte[2:0]);
          bytes_left_next = 2'd3;
        end
        default: begin
          // stray continuation or 0xF8..0xFF lead: dropped
          code_accum_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      code_accum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        bytes_left <= bytes_left_next;
        code_accum <= code_accum_next;
      end
      if (in_xfer && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_byte <= map_cp(code_accum_next);
    end
  end

`ifndef SYNTH
  a_ascii_passthru: assert property (@(posedge clk) disable iff (rst)
    in_xfer && bytes_left == 2'd0 && !in_byte[7] && in_byte != '0
    |=> out_valid && out_byte == $past(in_byte))
    else $error("ASCII byte not passed through");

  a_no_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte != '0)
    else $error("zero byte on output");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    in_xfer && bytes_left != 2'd0 |=> bytes_left == $past(bytes_left) - 2'd1)
    else $error("continuation count did not step");

  a_cont_silent: assert property (@(posedge clk) disable iff (rst)
    in_xfer && bytes_left > 2'd1 && !out_valid |=> !out_valid)
    else $error("result on mid-sequence byte");
`endif

endmodule
